// ----- rtl/wma_pkg.sv -----
`default_nettype none
package wma_pkg;

  localparam int unsigned PRICE_W    = 32;
  localparam int unsigned VOL_W      = 24;
  localparam int unsigned PROD_W     = PRICE_W + VOL_W;
  localparam int unsigned PSUM_W     = 38;
  localparam int unsigned WSUM_W     = 62;
  localparam int unsigned VSUM_W     = 30;
  localparam int unsigned LEN_W      = 7;
  localparam int unsigned QUO_W      = 32;
  localparam int unsigned DIV_CNT_W  = 6;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 30;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam int unsigned WINDOW_MAX  = 64;
  localparam int unsigned RING_ADDR_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AVERAGE_MODE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_VOLUME_SUM = 2'd2;

  localparam logic [DIV_CNT_W-1:0] DIV_STEPS = 6'd32;

  typedef struct packed {
    logic [WSUM_W-1:0] dividend;
    logic [VSUM_W-1:0] divisor;
    logic              full;
    logic              too_small;
  } job_t;

  typedef struct packed {
    logic [QUO_W-1:0] value;
    logic             full;
    logic             too_small;
  } result_t;

endpackage
`default_nettype wire

// ----- rtl/windowed_moving_average_top.sv -----
`default_nettype none
// Windowed moving average over a stream of price and volume samples, giving
// either the plain mean of the last window_length prices or the volume
// weighted mean. The front end takes a sample when it is idle: it reads the
// oldest sample from the ring memory, forms both products on the next cycle,
// then retires and adds into the running sums and queues a division request.
// The back end runs a restoring divider, one quotient bit per cycle; a
// request that divides passes through load, 32 steps and the hand-over to
// the output register; while the window is filling, or the volume sum is
// too small, a request skips the steps and goes from load to hand-over. The
// front end can take the next sample while the back end still divides, with
// the job queue between them. The ring memory needs no clearing pass after reset.
module windowed_moving_average_top (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [wma_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [wma_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [wma_pkg::PRICE_W-1:0]    close_price_i,
  input  wire logic [wma_pkg::VOL_W-1:0]      trade_volume_i,
  input  wire logic                           series_start_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic      [wma_pkg::QUO_W-1:0]      average_value_o,
  output logic                                window_full_o,
  output logic                                volume_too_small_o
);
  import wma_pkg::*;

  localparam int unsigned ADDR_W = RING_ADDR_W;

  logic              push, pop, q_full, q_empty;
  job_t              push_job, pop_job;
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [PROD_W-1:0] ram_wdata, ram_rdata;

  wma_ram #(
    .WIDTH (PROD_W),
    .DEPTH (WINDOW_MAX),
    .ADDR_W(ADDR_W)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  wma_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .close_price_i (close_price_i),
    .trade_volume_i(trade_volume_i),
    .series_start_i(series_start_i),
    .push_o        (push),
    .job_o         (push_job),
    .queue_full_i  (q_full),
    .ram_we_o      (ram_we),
    .ram_waddr_o   (ram_waddr),
    .ram_wdata_o   (ram_wdata),
    .ram_re_o      (ram_re),
    .ram_raddr_o   (ram_raddr),
    .ram_rdata_i   (ram_rdata)
  );

  wma_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (push_job),
    .full_o (q_full),
    .pop_i  (pop),
    .job_o  (pop_job),
    .empty_o(q_empty)
  );

  wma_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .queue_empty_i     (q_empty),
    .job_i             (pop_job),
    .pop_o             (pop),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .average_value_o   (average_value_o),
    .window_full_o     (window_full_o),
    .volume_too_small_o(volume_too_small_o)
  );

endmodule
`default_nettype wire

// ----- rtl/wma_ram.sv -----
`default_nettype none
module wma_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/wma_front.sv -----
`default_nettype none
module wma_front (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [wma_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [wma_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [wma_pkg::PRICE_W-1:0]    close_price_i,
  input  wire logic [wma_pkg::VOL_W-1:0]      trade_volume_i,
  input  wire logic                           series_start_i,
  output logic                                push_o,
  output wma_pkg::job_t                       job_o,
  input  wire logic                           queue_full_i,
  output logic                                ram_we_o,
  output logic      [wma_pkg::RING_ADDR_W-1:0] ram_waddr_o,
  output logic      [wma_pkg::PROD_W-1:0]     ram_wdata_o,
  output logic                                ram_re_o,
  output logic      [wma_pkg::RING_ADDR_W-1:0] ram_raddr_o,
  input  wire logic [wma_pkg::PROD_W-1:0]     ram_rdata_i
);
  import wma_pkg::*;

  localparam int unsigned ADDR_W = RING_ADDR_W;

  localparam logic [2:0] F_IDLE   = 3'd0;
  localparam logic [2:0] F_READ   = 3'd1;
  localparam logic [2:0] F_RETIRE = 3'd2;
  localparam logic [2:0] F_ADD    = 3'd3;
  localparam logic [2:0] F_PUSH   = 3'd4;

  logic [2:0]          state_q, state_d;
  logic [ADDR_W-1:0]   pos_q, pos_d;
  logic [LEN_W-1:0]    held_q, held_d;
  logic [PSUM_W-1:0]   psum_q, psum_d;
  logic [WSUM_W-1:0]   wsum_q, wsum_d;
  logic [VSUM_W-1:0]   vsum_q, vsum_d;
  logic [LEN_W-1:0]    wlen_q, wlen_d;
  logic                mode_q, mode_d;
  logic [VSUM_W-1:0]   minv_q, minv_d;

  logic [PRICE_W-1:0]  price_q;
  logic [VOL_W-1:0]    vol_q;
  logic [ADDR_W-1:0]   slot_q;
  logic                retire_q;
  logic [PRICE_W-1:0]  old_price_q;
  logic [VOL_W-1:0]    old_vol_q;
  logic [PROD_W-1:0]   old_prod_q;
  logic [PROD_W-1:0]   new_prod_q;

  logic                accept;
  logic [ADDR_W-1:0]   base_pos, cur_pos, next_pos;
  logic [LEN_W-1:0]    base_held;
  logic                retire;
  logic [LEN_W-1:0]    len_raw, len_clamped;
  logic                full, too_small;

  assign accept    = (state_q == F_IDLE) && in_valid_i;
  assign base_pos  = series_start_i ? '0 : pos_q;
  assign cur_pos   = (32'(base_pos) >= 32'(wlen_q)) ? '0 : base_pos;
  assign next_pos  = ((32'(cur_pos) + 32'd1) >= 32'(wlen_q)) ? '0 : ADDR_W'(cur_pos + 1'b1);
  assign base_held = series_start_i ? '0 : held_q;
  assign retire    = base_held >= wlen_q;

  assign len_raw = cfg_data_i[LEN_W-1:0];
  always_comb begin
    if (len_raw == '0) begin
      len_clamped = LEN_W'(1);
    end else if (32'(len_raw) > WINDOW_MAX) begin
      len_clamped = LEN_W'(WINDOW_MAX);
    end else begin
      len_clamped = len_raw;
    end
  end

  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    held_d  = held_q;
    psum_d  = psum_q;
    wsum_d  = wsum_q;
    vsum_d  = vsum_q;
    wlen_d  = wlen_q;
    mode_d  = mode_q;
    minv_d  = minv_q;
    case (state_q)
      F_IDLE: begin
        if (accept) begin
          if (series_start_i) begin
            psum_d = '0;
            wsum_d = '0;
            vsum_d = '0;
          end
          held_d  = retire ? base_held : LEN_W'(base_held + 1'b1);
          pos_d   = next_pos;
          state_d = F_READ;
        end
      end
      F_READ: begin
        state_d = F_RETIRE;
      end
      F_RETIRE: begin
        if (retire_q) begin
          psum_d = psum_q - PSUM_W'(old_price_q);
          wsum_d = wsum_q - WSUM_W'(old_prod_q);
          vsum_d = vsum_q - VSUM_W'(old_vol_q);
        end
        state_d = F_ADD;
      end
      F_ADD: begin
        psum_d  = psum_q + PSUM_W'(price_q);
        wsum_d  = wsum_q + WSUM_W'(new_prod_q);
        vsum_d  = vsum_q + VSUM_W'(vol_q);
        state_d = F_PUSH;
      end
      F_PUSH: begin
        if (!queue_full_i) begin
          state_d = F_IDLE;
        end
      end
      default: begin
        state_d = F_IDLE;
      end
    endcase
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_WINDOW_LENGTH: begin
          wlen_d = len_clamped;
          pos_d  = '0;
          held_d = '0;
          psum_d = '0;
          wsum_d = '0;
          vsum_d = '0;
        end
        CFG_AVERAGE_MODE: begin
          mode_d = cfg_data_i[0];
        end
        CFG_MIN_VOLUME_SUM: begin
          minv_d = cfg_data_i[VSUM_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      pos_q   <= '0;
      held_q  <= '0;
      psum_q  <= '0;
      wsum_q  <= '0;
      vsum_q  <= '0;
      wlen_q  <= LEN_W'(1);
      mode_q  <= 1'b0;
      minv_q  <= '0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      held_q  <= held_d;
      psum_q  <= psum_d;
      wsum_q  <= wsum_d;
      vsum_q  <= vsum_d;
      wlen_q  <= wlen_d;
      mode_q  <= mode_d;
      minv_q  <= minv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      price_q  <= close_price_i;
      vol_q    <= trade_volume_i;
      slot_q   <= cur_pos;
      retire_q <= retire;
    end
    if (state_q == F_READ) begin
      old_price_q <= ram_rdata_i[PROD_W-1:VOL_W];
      old_vol_q   <= ram_rdata_i[VOL_W-1:0];
      old_prod_q  <= PROD_W'(ram_rdata_i[PROD_W-1:VOL_W]) * PROD_W'(ram_rdata_i[VOL_W-1:0]);
      new_prod_q  <= PROD_W'(price_q) * PROD_W'(vol_q);
    end
  end

  assign ram_re_o    = accept;
  assign ram_raddr_o = cur_pos;
  assign ram_we_o    = (state_q == F_ADD);
  assign ram_waddr_o = slot_q;
  assign ram_wdata_o = {price_q, vol_q};

  assign full      = held_q >= wlen_q;
  assign too_small = full && mode_q && !((vsum_q > minv_q) && (vsum_q != '0));

  assign in_ready_o      = (state_q == F_IDLE);
  assign push_o          = (state_q == F_PUSH) && !queue_full_i;
  assign job_o.dividend  = mode_q ? wsum_q : WSUM_W'(psum_q);
  assign job_o.divisor   = mode_q ? vsum_q : VSUM_W'(wlen_q);
  assign job_o.full      = full;
  assign job_o.too_small = too_small;

`ifndef NO_ASSERTIONS
  a_series_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && series_start_i && !cfg_we_i) |=> (held_q == LEN_W'(1)))
    else $error("series start did not leave one sample in the window");
  a_position_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(pos_q) < 32'(wlen_q)))
    else $error("ring position outside the window");
`endif

endmodule
`default_nettype wire

// ----- rtl/wma_queue.sv -----
`default_nettype none
module wma_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire wma_pkg::job_t job_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output wma_pkg::job_t      job_o,
  output logic               empty_o
);
  import wma_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             entry_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (32'(wr_q) == QUEUE_DEPTH - 1) ? '0 : PTR_W'(wr_q + 1'b1);
    end
    if (pop_i) begin
      rd_d = (32'(rd_q) == QUEUE_DEPTH - 1) ? '0 : PTR_W'(rd_q + 1'b1);
    end
    if (push_i && !pop_i) begin
      cnt_d = CNT_W'(cnt_q + 1'b1);
    end else if (pop_i && !push_i) begin
      cnt_d = CNT_W'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_q] <= job_i;
    end
  end

  assign full_o  = (32'(cnt_q) == QUEUE_DEPTH);
  assign empty_o = (cnt_q == '0);
  assign job_o   = entry_q[rd_q];

`ifndef NO_ASSERTIONS
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o) && !(pop_i && empty_o))
    else $error("job queue pushed while full or popped while empty");
`endif

endmodule
`default_nettype wire

// ----- rtl/wma_back.sv -----
`default_nettype none
module wma_back (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       queue_empty_i,
  input  wire wma_pkg::job_t              job_i,
  output logic                            pop_o,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [wma_pkg::QUO_W-1:0]       average_value_o,
  output logic                            window_full_o,
  output logic                            volume_too_small_o
);
  import wma_pkg::*;

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_DIV  = 2'd1;
  localparam logic [1:0] B_HOLD = 2'd2;

  logic [1:0]           state_q, state_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [VSUM_W-1:0]    rem_q, rem_d;
  logic [QUO_W-1:0]     quo_q, quo_d;
  logic [VSUM_W-1:0]    div_q, div_d;
  logic                 full_q, full_d;
  logic                 small_q, small_d;
  logic                 out_valid_q, out_valid_d;
  result_t              out_q, out_d;

  logic [VSUM_W:0]      shifted, diff;
  logic                 ge;
  logic                 load_out;

  assign shifted  = {rem_q, quo_q[QUO_W-1]};
  assign diff     = shifted - {1'b0, div_q};
  assign ge       = shifted >= {1'b0, div_q};
  assign load_out = (state_q == B_HOLD) && (!out_valid_q || out_ready_i);
  assign pop_o    = (state_q == B_IDLE) && !queue_empty_i;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    div_d       = div_q;
    full_d      = full_q;
    small_d     = small_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      B_IDLE: begin
        if (pop_o) begin
          full_d  = job_i.full;
          small_d = job_i.too_small;
          div_d   = job_i.divisor;
          rem_d   = job_i.dividend[WSUM_W-1:QUO_W];
          cnt_d   = DIV_STEPS;
          if (job_i.full && !job_i.too_small) begin
            quo_d   = job_i.dividend[QUO_W-1:0];
            state_d = B_DIV;
          end else begin
            quo_d   = '0;
            state_d = B_HOLD;
          end
        end
      end
      B_DIV: begin
        rem_d = ge ? diff[VSUM_W-1:0] : shifted[VSUM_W-1:0];
        quo_d = {quo_q[QUO_W-2:0], ge};
        cnt_d = DIV_CNT_W'(cnt_q - 1'b1);
        if (cnt_q == DIV_CNT_W'(1)) begin
          state_d = B_HOLD;
        end
      end
      B_HOLD: begin
        if (load_out) begin
          out_d.value     = quo_q;
          out_d.full      = full_q;
          out_d.too_small = small_q;
          out_valid_d     = 1'b1;
          state_d         = B_IDLE;
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    div_q   <= div_d;
    full_q  <= full_d;
    small_q <= small_d;
    out_q   <= out_d;
  end

  assign out_valid_o        = out_valid_q;
  assign average_value_o    = out_q.value;
  assign window_full_o      = out_q.full;
  assign volume_too_small_o = out_q.too_small;

`ifndef NO_ASSERTIONS
  a_divide_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_DIV) |-> (cnt_q != '0))
    else $error("divider running with an exhausted step count");
`endif

endmodule
`default_nettype wire

// ----- tb/moving_average_checker.sv -----
module moving_average_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [wma_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [wma_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                in_valid_i,
  input  logic                                in_ready_i,
  input  logic [wma_pkg::PRICE_W-1:0]         close_price_i,
  input  logic [wma_pkg::VOL_W-1:0]           trade_volume_i,
  input  logic                                series_start_i,
  input  logic                                out_valid_i,
  input  logic                                out_ready_i,
  input  logic [wma_pkg::QUO_W-1:0]           average_value_i,
  input  logic                                window_full_i,
  input  logic                                volume_too_small_i,
  output int unsigned                         mismatches_o,
  output int unsigned                         outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import wma_pkg::*;

  localparam int unsigned REPORT_LIMIT = 100;

  logic [PRICE_W-1:0] price_hist [WINDOW_MAX];
  logic [VOL_W-1:0]   volume_hist [WINDOW_MAX];
  int unsigned        slot = 0;
  int unsigned        taken = 0;
  logic [PSUM_W-1:0]  price_total = '0;
  logic [WSUM_W-1:0]  weighted_total = '0;
  logic [VSUM_W-1:0]  volume_total = '0;

  int unsigned        span = 1;
  logic               weighted_mode = 1'b0;
  logic [VSUM_W-1:0]  volume_floor = '0;

  result_t            expected_averages [$];
  result_t            predicted;

  initial mismatches_o = 0;

  task automatic report_mismatch(input string field, input logic [QUO_W-1:0] seen,
                                 input logic [QUO_W-1:0] wanted);
    if (mismatches_o < REPORT_LIMIT) begin
      $display("%0t ns: %s is %0h, expected %0h", $time, field, seen, wanted);
    end
    mismatches_o++;
  endtask

  task automatic restart_series();
    slot = 0;
    taken = 0;
    price_total = '0;
    weighted_total = '0;
    volume_total = '0;
  endtask

  task automatic apply_write(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
    int unsigned len;
    case (index)
      CFG_WINDOW_LENGTH: begin
        len = 32'(data[LEN_W-1:0]);
        if (len == 0) len = 1;
        if (len > WINDOW_MAX) len = WINDOW_MAX;
        span = len;
        restart_series();
      end
      CFG_AVERAGE_MODE: begin
        weighted_mode = data[0];
      end
      CFG_MIN_VOLUME_SUM: begin
        volume_floor = data[VSUM_W-1:0];
      end
      default: begin
      end
    endcase
  endtask

  task automatic advance_window(input logic [PRICE_W-1:0] price, input logic [VOL_W-1:0] volume,
                                input logic restart, output result_t average);
    int unsigned        pos;
    logic [PRICE_W-1:0] old_price;
    logic [VOL_W-1:0]   old_volume;
    logic [WSUM_W-1:0]  quotient;
    quotient = '0;
    average = '0;
    if (restart) restart_series();
    pos = (slot >= span) ? 0 : slot;
    if (taken >= span) begin
      // The slot holds the oldest sample of the window, which now drops out.
      old_price = price_hist[pos[RING_ADDR_W-1:0]];
      old_volume = volume_hist[pos[RING_ADDR_W-1:0]];
      price_total = price_total - PSUM_W'(old_price);
      weighted_total = weighted_total - WSUM_W'(old_price) * WSUM_W'(old_volume);
      volume_total = volume_total - VSUM_W'(old_volume);
    end else begin
      taken++;
    end
    price_hist[pos[RING_ADDR_W-1:0]] = price;
    volume_hist[pos[RING_ADDR_W-1:0]] = volume;
    price_total = price_total + PSUM_W'(price);
    weighted_total = weighted_total + WSUM_W'(price) * WSUM_W'(volume);
    volume_total = volume_total + VSUM_W'(volume);
    pos++;
    if (pos >= span) pos = 0;
    slot = pos;
    if (taken >= span) begin
      average.full = 1'b1;
      if (!weighted_mode) begin
        quotient = WSUM_W'(price_total / span);
      end else if (volume_total > volume_floor && volume_total != '0) begin
        quotient = weighted_total / WSUM_W'(volume_total);
      end else begin
        average.too_small = 1'b1;
      end
      average.value = quotient[QUO_W-1:0];
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      span = 1;
      weighted_mode = 1'b0;
      volume_floor = '0;
      restart_series();
      expected_averages.delete();
      outstanding_o <= 0;
    end else begin
      if (cfg_we_i) apply_write(cfg_index_i, cfg_data_i);
      if (in_valid_i && in_ready_i) begin
        advance_window(close_price_i, trade_volume_i, series_start_i, predicted);
        expected_averages = {expected_averages, predicted};
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_averages.size() == 0) begin
          report_mismatch("result with no request pending, average_value", average_value_i, '0);
        end else begin
          predicted = expected_averages.pop_front();
          if (average_value_i !== predicted.value) begin
            report_mismatch("average_value", average_value_i, predicted.value);
          end
          if (window_full_i !== predicted.full) begin
            report_mismatch("window_full", QUO_W'(window_full_i), QUO_W'(predicted.full));
          end
          if (volume_too_small_i !== predicted.too_small) begin
            report_mismatch("volume_too_small", QUO_W'(volume_too_small_i),
                            QUO_W'(predicted.too_small));
          end
        end
      end
      outstanding_o <= expected_averages.size();
    end
  end

endmodule

// ----- tb/windowed_moving_average_top_test.sv -----
module windowed_moving_average_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import wma_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX = 2'd3;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES = 40;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [PRICE_W-1:0]    close_price_i = '0;
  logic [VOL_W-1:0]      trade_volume_i = '0;
  logic                  series_start_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [QUO_W-1:0]      average_value_o;
  logic                  window_full_o;
  logic                  volume_too_small_o;

  int unsigned mismatches;
  int unsigned outstanding;
  bit          no_gaps = 1'b0;
  bit          hold_due = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  windowed_moving_average_top dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .close_price_i      (close_price_i),
    .trade_volume_i     (trade_volume_i),
    .series_start_i     (series_start_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .average_value_o    (average_value_o),
    .window_full_o      (window_full_o),
    .volume_too_small_o (volume_too_small_o)
  );

  moving_average_checker average_check (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_ready_i         (in_ready_o),
    .close_price_i      (close_price_i),
    .trade_volume_i     (trade_volume_i),
    .series_start_i     (series_start_i),
    .out_valid_i        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .average_value_i    (average_value_o),
    .window_full_i      (window_full_o),
    .volume_too_small_i (volume_too_small_o),
    .mismatches_o       (mismatches),
    .outstanding_o      (outstanding)
  );

  function automatic int unsigned idle_cycles();
    return no_gaps ? 0 : $urandom_range(0, 4);
  endfunction

  function automatic logic [PRICE_W-1:0] random_price();
    case ($urandom_range(0, 7))
      0: return '1;
      1: return '0;
      2: return $urandom_range(0, 32'h0004_0000);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [VOL_W-1:0] random_volume();
    case ($urandom_range(0, 7))
      0: return '1;
      1: return '0;
      2: return VOL_W'($urandom_range(0, 15));
      default: return VOL_W'($urandom());
    endcase
  endfunction

  task automatic send_sample(input logic [PRICE_W-1:0] price, input logic [VOL_W-1:0] volume,
                             input logic restart);
    int unsigned gap;
    gap = idle_cycles();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    close_price_i <= price;
    trade_volume_i <= volume;
    series_start_i <= restart;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input int unsigned data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i <= CFG_DATA_W'(data);
    @(posedge clk_i);
  endtask

  task automatic configure(input int unsigned span, input int unsigned mode,
                           input int unsigned floor_value);
    write_reg(CFG_WINDOW_LENGTH, span);
    write_reg(CFG_AVERAGE_MODE, mode);
    write_reg(CFG_MIN_VOLUME_SUM, floor_value);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_burst(input int unsigned count, input int unsigned restart_odds);
    repeat (count) begin
      send_sample(random_price(), random_volume(), $urandom_range(1, restart_odds) == 1);
    end
    drain();
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The window length is still at its reset value of one here.
    send_sample('1, '1, 1'b1);
    send_sample('0, '0, 1'b0);
    send_sample(32'h0001_8000, 24'd3, 1'b0);
    drain();

    // A window length of zero is taken as one; a zero volume sum is too small.
    write_reg(CFG_WINDOW_LENGTH, '0);
    write_reg(CFG_AVERAGE_MODE, 1);
    cfg_we_i <= 1'b0;
    send_sample('1, '1, 1'b0);
    send_sample(32'h1234_5678, '0, 1'b0);
    send_sample(32'hABCD_0000, 24'd5, 1'b0);
    drain();

    // The highest threshold keeps the weighted result suppressed.
    configure(4, 1, '1);
    repeat (5) send_sample('1, '1, 1'b0);
    drain();

    // The mode changes in the middle of a series; the spare index does nothing.
    write_reg(CFG_AVERAGE_MODE, 0);
    write_reg(CFG_SPARE_INDEX, '1);
    cfg_we_i <= 1'b0;
    send_sample(32'h0000_0001, 24'h00_0001, 1'b0);
    send_sample(32'h8000_0000, 24'h80_0000, 1'b0);
    send_sample(32'hFFFF_FFFE, 24'h7F_FFFF, 1'b1);
    drain();

    configure($urandom_range(2, 8), 1, $urandom_range(0, 1 << 25));
    random_burst(80, 40);

    hold_due = 1'b1;
    configure(WINDOW_MAX, 0, 0);
    random_burst(130, 400);

    no_gaps = 1'b1;
    configure(0, 1, 0);
    random_burst(40, 10);
    no_gaps = 1'b0;

    // A length above the largest window is clamped to it.
    configure(127, 1, $urandom_range(0, 1 << 29));
    random_burst(100, 400);
    write_reg(CFG_AVERAGE_MODE, 0);
    cfg_we_i <= 1'b0;
    random_burst(30, 400);

    hold_due = 1'b1;
    configure($urandom_range(1, 16), $urandom_range(0, 1), $urandom_range(0, (1 << 30) - 1));
    random_burst(60, 40);

    configure($urandom(), $urandom(), $urandom());
    random_burst(60, 40);

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("windowed_moving_average_top test passed");
    end else begin
      $display("windowed_moving_average_top test failed");
    end
    $finish;
  end

  initial begin
    int unsigned gap;
    wait (rst_ni);
    forever begin
      if (hold_due) begin
        // A long hold-off lets the block fill up and refuse further requests.
        hold_due = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      gap = idle_cycles();
      if (gap != 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  initial begin
    #5_000_000;
    $display("windowed_moving_average_top test failed");
    $finish;
  end

endmodule
